// ===== design/awa_pkg.sv =====
// ----------------------------------------------------------------------------
// awa_pkg
// Shared types, widths, constants and the CORDIC arctangent table for the
// Ackermann wheel angle unit.
// ----------------------------------------------------------------------------
package awa_pkg;

	// Field widths
	localparam int IN_W      = 15;
	localparam int OUT_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Internal widths: angles in 2^-24 rad, rotation and vectoring datapaths
	localparam int ANG_W  = 28;
	localparam int ROT_W  = 33;
	localparam int PROD_W = 50;
	localparam int VEC_W  = 52;
	localparam int MAG_W  = 14;

	localparam int TAB_LEN      = 24;
	localparam int TAB_IDX_W    = 5;
	localparam int DEF_ITER     = 16;

	localparam logic signed [ANG_W-1:0] HALF_PI_Z   = ANG_W'(26353589);
	localparam logic signed [IN_W-1:0]  MAX_IN_Q13  = IN_W'(12867);
	localparam logic signed [OUT_W-1:0] MAX_OUT_Q13 = OUT_W'(25736);

	localparam logic [CFG_W-1:0] WHEELBASE_RST = CFG_W'(2480);
	localparam logic [CFG_W-1:0] OFFSET_RST    = CFG_W'(105);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 1'b1;

	// Sideband that travels with each beat
	typedef struct packed {
		logic neg;
		logic zero;
	} flags_t;

	// round(atan(2^-i) * 2^24)
	function automatic logic signed [ANG_W-1:0] ang_tab(input logic [TAB_IDX_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		unique case (idx)
			5'd0:  r = ANG_W'(13176795);
			5'd1:  r = ANG_W'(7778717);
			5'd2:  r = ANG_W'(4110060);
			5'd3:  r = ANG_W'(2086331);
			5'd4:  r = ANG_W'(1047214);
			5'd5:  r = ANG_W'(524117);
			5'd6:  r = ANG_W'(262123);
			5'd7:  r = ANG_W'(131069);
			5'd8:  r = ANG_W'(65536);
			5'd9:  r = ANG_W'(32768);
			5'd10: r = ANG_W'(16384);
			5'd11: r = ANG_W'(8192);
			5'd12: r = ANG_W'(4096);
			5'd13: r = ANG_W'(2048);
			5'd14: r = ANG_W'(1024);
			5'd15: r = ANG_W'(512);
			5'd16: r = ANG_W'(256);
			5'd17: r = ANG_W'(128);
			5'd18: r = ANG_W'(64);
			5'd19: r = ANG_W'(32);
			5'd20: r = ANG_W'(16);
			5'd21: r = ANG_W'(8);
			5'd22: r = ANG_W'(4);
			5'd23: r = ANG_W'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/awa_rot.sv =====
// ----------------------------------------------------------------------------
// awa_rot
// Unrolled rotation-mode CORDIC, one register stage per step. Gives the
// gain-scaled cosine and sine of the incoming angle.
// ----------------------------------------------------------------------------
module awa_rot #(
	parameter int ITER = awa_pkg::DEF_ITER
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  awa_pkg::flags_t                      in_flags,
	input  logic signed [awa_pkg::ANG_W-1:0]     in_z,
	output logic                                 out_valid,
	output awa_pkg::flags_t                      out_flags,
	output logic signed [awa_pkg::ROT_W-1:0]     out_x,
	output logic signed [awa_pkg::ROT_W-1:0]     out_y
);
	import awa_pkg::*;

	localparam int N = (ITER < TAB_LEN) ? ITER : TAB_LEN;

	logic                    v_s [0:N];
	flags_t                  f_s [0:N];
	logic signed [ROT_W-1:0] x_s [0:N];
	logic signed [ROT_W-1:0] y_s [0:N];
	logic signed [ANG_W-1:0] z_s [0:N];

	// Stage 0: seed vector on the x axis
	assign v_s[0] = in_valid;
	assign f_s[0] = in_flags;
	assign x_s[0] = ROT_W'(64'sd1 << 30);
	assign y_s[0] = '0;
	assign z_s[0] = in_z;

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// One micro-rotation, direction from the sign of z
		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ang_tab(TAB_IDX_W'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ang_tab(TAB_IDX_W'(i));
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_flags = f_s[N];
	assign out_x     = x_s[N];
	assign out_y     = y_s[N];

endmodule

// ===== design/awa_vec.sv =====
// ----------------------------------------------------------------------------
// awa_vec
// Unrolled vectoring-mode CORDIC giving atan2(y, x): a registered quadrant
// fold-in followed by one register stage per step.
// ----------------------------------------------------------------------------
module awa_vec #(
	parameter int ITER = awa_pkg::DEF_ITER
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  awa_pkg::flags_t                      in_flags,
	input  logic signed [awa_pkg::VEC_W-1:0]     in_x,
	input  logic signed [awa_pkg::VEC_W-1:0]     in_y,
	output logic                                 out_valid,
	output awa_pkg::flags_t                      out_flags,
	output logic signed [awa_pkg::ANG_W-1:0]     out_z
);
	import awa_pkg::*;

	localparam int N = (ITER < TAB_LEN) ? ITER : TAB_LEN;

	logic                    v_s [0:N];
	flags_t                  f_s [0:N];
	logic signed [VEC_W-1:0] x_s [0:N];
	logic signed [VEC_W-1:0] y_s [0:N];
	logic signed [ANG_W-1:0] z_s [0:N];

	// Fold the left half-plane onto the right by a quarter turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		f_s[0] <= in_flags;
		if (in_x < 0 && in_y >= 0) begin
			x_s[0] <= in_y;
			y_s[0] <= -in_x;
			z_s[0] <= HALF_PI_Z;
		end else if (in_x < 0) begin
			x_s[0] <= -in_y;
			y_s[0] <= in_x;
			z_s[0] <= -HALF_PI_Z;
		end else begin
			x_s[0] <= in_x;
			y_s[0] <= in_y;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Drive y towards zero, accumulating the angle
		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ang_tab(TAB_IDX_W'(i));
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ang_tab(TAB_IDX_W'(i));
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_flags = f_s[N];
	assign out_z     = z_s[N];

endmodule

// ===== design/ackermann_wheel_angles_unit.sv =====
// ----------------------------------------------------------------------------
// ackermann_wheel_angles_unit
// Left and right front-wheel angles of Ackermann steering from one reference
// steering angle, via a rotation CORDIC and two vectoring CORDICs.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ----------------------
//  command   steer_angle                             start & !busy
//  result    left_angle, right_angle                 done, one-cycle strobe
//  config    cfg_index, cfg_data                     cfg_we
//
// One beat is taken every cycle; busy is never raised.
// Pipeline registers, in order: input register, ITER
// rotation steps, multiply, add, quadrant fold, ITER vectoring steps, output.
// Reset clears the valid bits and loads the default wheel geometry.
// The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module ackermann_wheel_angles_unit #(
	parameter int CORDIC_ITERATIONS = awa_pkg::DEF_ITER
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [awa_pkg::IN_W-1:0]        steer_angle,
	output logic                                   done,
	output logic signed [awa_pkg::OUT_W-1:0]       left_angle,
	output logic signed [awa_pkg::OUT_W-1:0]       right_angle,
	input  logic                                   cfg_we,
	input  logic [awa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [awa_pkg::CFG_W-1:0]              cfg_data
);
	import awa_pkg::*;

	logic [CFG_W-1:0] wheelbase_q, offset_q;

	logic              v_s1;
	flags_t            f_s1;
	logic [MAG_W-1:0]  mag_s1;

	logic                    rot_valid;
	flags_t                  rot_flags;
	logic signed [ROT_W-1:0] rot_x, rot_y;

	logic                     v_s2;
	flags_t                   f_s2;
	logic signed [PROD_W-1:0] ly_s2, lc_s2, os_s2;

	logic                    v_s3;
	flags_t                  f_s3;
	logic signed [VEC_W-1:0] y_s3, xl_s3, xr_s3;

	logic                    vl_valid, vr_valid;
	flags_t                  vl_flags, vr_flags;
	logic signed [ANG_W-1:0] zl, zr;

	logic signed [IN_W-1:0]  a_sat;
	logic signed [CFG_W:0]   lw, ow;
	logic signed [OUT_W-1:0] ql, qr;

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= WHEELBASE_RST;
			offset_q    <= OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WHEELBASE: wheelbase_q <= cfg_data;
				REG_OFFSET:    offset_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: clamp the command, split sign and magnitude
	always_comb begin
		if (steer_angle > MAX_IN_Q13) begin
			a_sat = MAX_IN_Q13;
		end else if (steer_angle < -MAX_IN_Q13) begin
			a_sat = -MAX_IN_Q13;
		end else begin
			a_sat = steer_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		f_s1.neg  <= a_sat[IN_W-1];
		f_s1.zero <= (a_sat == '0);
		mag_s1    <= MAG_W'(a_sat[IN_W-1] ? -a_sat : a_sat);
	end

	awa_rot #(.ITER(CORDIC_ITERATIONS)) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_flags  (f_s1),
		.in_z      (ANG_W'({mag_s1, 11'b0})),
		.out_valid (rot_valid),
		.out_flags (rot_flags),
		.out_x     (rot_x),
		.out_y     (rot_y)
	);

	// Stage 2: products with the geometry; zero wheelbase reads as one
	assign lw = (wheelbase_q == '0) ? (CFG_W+1)'(1) : $signed({1'b0, wheelbase_q});
	assign ow = $signed({1'b0, offset_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		f_s2  <= rot_flags;
		ly_s2 <= PROD_W'(lw * rot_y);
		lc_s2 <= PROD_W'(lw * rot_x);
		os_s2 <= PROD_W'(ow * rot_y);
	end

	// Stage 3: x for each wheel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		f_s3  <= f_s2;
		y_s3  <= VEC_W'(ly_s2);
		xl_s3 <= VEC_W'(lc_s2) - VEC_W'(os_s2);
		xr_s3 <= VEC_W'(lc_s2) + VEC_W'(os_s2);
	end

	awa_vec #(.ITER(CORDIC_ITERATIONS)) u_vec_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_flags  (f_s3),
		.in_x      (xl_s3),
		.in_y      (y_s3),
		.out_valid (vl_valid),
		.out_flags (vl_flags),
		.out_z     (zl)
	);

	awa_vec #(.ITER(CORDIC_ITERATIONS)) u_vec_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_flags  (f_s3),
		.in_x      (xr_s3),
		.in_y      (y_s3),
		.out_valid (vr_valid),
		.out_flags (vr_flags),
		.out_z     (zr)
	);

	// Round to Q2.13 and clamp
	function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [ANG_W-1:0] z);
		logic signed [ANG_W:0] q;
		q = ($signed({z[ANG_W-1], z}) + (ANG_W+1)'(1024)) >>> 11;
		if (q > (ANG_W+1)'(MAX_OUT_Q13)) begin
			return MAX_OUT_Q13;
		end else if (q < -(ANG_W+1)'(MAX_OUT_Q13)) begin
			return -MAX_OUT_Q13;
		end
		return OUT_W'(q);
	endfunction

	assign ql = to_q13(zl);
	assign qr = to_q13(zr);

	// Output stage: mirror for negative commands, zero command gives zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vl_valid & vr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vl_flags.zero) begin
			left_angle  <= '0;
			right_angle <= '0;
		end else if (vr_flags.neg) begin
			left_angle  <= -qr;
			right_angle <= -ql;
		end else begin
			left_angle  <= ql;
			right_angle <= qr;
		end
	end

endmodule
